// ----- sv/hbls_pkg.sv -----
`timescale 1ns / 1ps
package hbls_pkg;

  localparam int unsigned ColumnsPerDigit = 5;
  localparam int unsigned SweepColumns    = 2 * ColumnsPerDigit;

  localparam logic [15:0] DwellReset = 16'd650;
  localparam logic [6:0]  RowsIdle   = 7'h7F;
  localparam logic [4:0]  SelOff     = 5'h1F;
  localparam logic [4:0]  SelIdle    = 5'h00;

  typedef logic [3:0] column_t;
  typedef logic [2:0] sub_t;

  // one lit column as it leaves the scanner
  typedef struct packed {
    logic [3:0] column_now;
    logic [4:0] right_select;
    logic [4:0] left_select;
    logic [6:0] row_pattern;
  } scan_word_t;

  // active-low one-hot select for the column within a matrix
  function automatic logic [4:0] col_select(input sub_t sub);
    logic [4:0] sel;
    case (sub)
      3'd0:    sel = 5'h0F;
      3'd1:    sel = 5'h17;
      3'd2:    sel = 5'h1B;
      3'd3:    sel = 5'h1D;
      3'd4:    sel = 5'h1E;
      default: sel = SelOff;
    endcase
    return sel;
  endfunction

  // 5x7 hex font, one column per entry, bit 6 is the top row
  function automatic logic [6:0] hex_font(input logic [3:0] digit, input sub_t sub);
    logic [34:0] glyph;
    logic [6:0]  col;
    case (digit)
      4'h0: glyph = {7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E};
      4'h1: glyph = {7'h00, 7'h01, 7'h7F, 7'h21, 7'h00};
      4'h2: glyph = {7'h31, 7'h49, 7'h45, 7'h43, 7'h21};
      4'h3: glyph = {7'h46, 7'h69, 7'h51, 7'h41, 7'h42};
      4'h4: glyph = {7'h04, 7'h7F, 7'h24, 7'h14, 7'h0C};
      4'h5: glyph = {7'h4E, 7'h51, 7'h51, 7'h51, 7'h72};
      4'h6: glyph = {7'h06, 7'h49, 7'h49, 7'h29, 7'h1E};
      4'h7: glyph = {7'h60, 7'h50, 7'h48, 7'h47, 7'h40};
      4'h8: glyph = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
      4'h9: glyph = {7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30};
      4'hA: glyph = {7'h3F, 7'h44, 7'h44, 7'h44, 7'h3F};
      4'hB: glyph = {7'h36, 7'h49, 7'h49, 7'h49, 7'h7F};
      4'hC: glyph = {7'h22, 7'h41, 7'h41, 7'h41, 7'h3E};
      4'hD: glyph = {7'h1C, 7'h22, 7'h41, 7'h41, 7'h7F};
      4'hE: glyph = {7'h41, 7'h49, 7'h49, 7'h49, 7'h7F};
      default: glyph = {7'h40, 7'h48, 7'h48, 7'h48, 7'h7F};
    endcase
    case (sub)
      3'd0:    col = glyph[6:0];
      3'd1:    col = glyph[13:7];
      3'd2:    col = glyph[20:14];
      3'd3:    col = glyph[27:21];
      default: col = glyph[34:28];
    endcase
    return col;
  endfunction

endpackage

// ----- sv/hex_byte_led_matrix_scanner.sv -----
`timescale 1ns / 1ps
// An accepted tick's column word is registered in out_q, or held in skid_q first while out_q waits.
// Throughput: one word per cycle while m_axis takes them; the column logic is a single registered pass.
// A skid stage keeps s_axis_tready high while one finished word waits downstream.
// Reset (rst_ni low, asynchronous): dwell 650, scan at column 0, outputs idle
// (rows 0x7F, selects 0) and no word valid.
module hex_byte_led_matrix_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] shown_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [6:0] row_pattern, [11:7] left_select, [16:12] right_select,
  // [20:17] column_now, [23:21] zero
  output logic [23:0] m_axis_tdata_o
);
  import hbls_pkg::*;

  scan_word_t word;
  scan_word_t out_q, skid_q;
  logic       out_valid_q, skid_valid_q;
  logic       accept, take;

  assign s_axis_tready_o = !skid_valid_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign take            = out_valid_q && m_axis_tready_i;

  hbls_scan_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .tick_i      (accept),
    .shown_byte_i(s_axis_tdata_i),
    .word_o      (word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
      out_q        <= '{column_now: '0, right_select: SelIdle,
                        left_select: SelIdle, row_pattern: RowsIdle};
    end else begin
      if (skid_valid_q) begin
        if (take) begin
          out_q        <= skid_q;
          skid_valid_q <= 1'b0;
        end
      end else if (accept) begin
        if (!out_valid_q || take) begin
          out_q       <= word;
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept && out_valid_q && !take) begin
      skid_q <= word;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_q};

endmodule

// ----- sv/hbls_scan_core.sv -----
`timescale 1ns / 1ps
module hbls_scan_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                tick_i,
  input  logic [7:0]          shown_byte_i,
  output hbls_pkg::scan_word_t word_o
);
  import hbls_pkg::*;

  logic [15:0] dwell_ticks_q;
  logic [7:0]  latched_byte_q, latched_byte_d;
  column_t     column_count_q, column_count_d;
  logic [15:0] dwell_count_q, dwell_count_d;

  column_t     col;
  logic [15:0] dwc;
  logic [15:0] limit;
  logic [15:0] dwc_inc;
  sub_t        sub;
  logic        left_side;
  logic [3:0]  nibble;

  always_comb begin
    // an out-of-range column restarts the sweep
    if (column_count_q >= column_t'(SweepColumns)) begin
      col = '0;
      dwc = '0;
    end else begin
      col = column_count_q;
      dwc = dwell_count_q;
    end

    latched_byte_d = latched_byte_q;
    if (col == '0 && dwc == '0) begin
      latched_byte_d = shown_byte_i;
    end

    left_side = col < column_t'(ColumnsPerDigit);
    if (left_side) begin
      sub    = sub_t'(col);
      nibble = latched_byte_d[7:4];
    end else begin
      sub    = sub_t'(col - column_t'(ColumnsPerDigit));
      nibble = latched_byte_d[3:0];
    end

    word_o.row_pattern  = hex_font(nibble, sub);
    word_o.left_select  = left_side ? col_select(sub) : SelOff;
    word_o.right_select = left_side ? SelOff : col_select(sub);
    word_o.column_now   = col;

    limit   = (dwell_ticks_q == '0) ? 16'd1 : dwell_ticks_q;
    dwc_inc = dwc + 16'd1;
    if (dwc_inc >= limit || dwc_inc == '0) begin
      dwell_count_d  = '0;
      column_count_d = (col == column_t'(SweepColumns - 1)) ? '0 : col + 4'd1;
    end else begin
      dwell_count_d  = dwc_inc;
      column_count_d = col;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_ticks_q  <= DwellReset;
      latched_byte_q <= '0;
      column_count_q <= '0;
      dwell_count_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        dwell_ticks_q <= cfg_wdata_i;
      end
      if (tick_i) begin
        latched_byte_q <= latched_byte_d;
        column_count_q <= column_count_d;
        dwell_count_q  <= dwell_count_d;
      end
    end
  end

endmodule
